// ===== rtl/indexed_deadline_min_heap_macros.svh =====
// Assertion macros used by the port-level checker of the deadline min-heap.
// Depends on nothing; include by bare file name.
`ifndef INDEXED_DEADLINE_MIN_HEAP_MACROS_SVH
`define INDEXED_DEADLINE_MIN_HEAP_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define IDMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define IDMH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/idmh_pkg.sv =====
// Package of the indexed deadline min-heap: sizes, codes and shared types.
// Depends on nothing.
package idmh_pkg;
  localparam int unsigned CAPACITY_DEF      = 1024;
  localparam int unsigned DEADLINE_BITS_DEF = 48;
  localparam int unsigned ID_BITS           = 10;
  localparam int unsigned ENTRY_IDS         = 1024;
  localparam int unsigned DL_OUT_BITS       = 48;
  localparam int unsigned CNT_OUT_BITS      = 11;

  localparam logic OP_UPSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // Outcome of one operation as handed from the engine to the output stage.
  typedef struct packed {
    logic [1:0] status;
    logic       min_valid;
  } res_ctl_t;
endpackage

// ===== rtl/indexed_deadline_min_heap.sv =====
// Indexed deadline min-heap top level: sequencer, slot memory and position map.
// Uses idmh_pkg, idmh_slot_mem and idmh_pos_mem.
//
// Input channel in_valid/in_ready carries operation, entry_id and new_deadline.
// Upsert inserts or re-keys an entry; remove takes it out of the heap. Result
// channel out_valid/out_ready carries status, the current minimum and count.
// One result follows every accepted transaction.
// The block works on one transaction at a time. A refused or absent transaction,
// or the remove of the last slot, passes through S_POS, S_DEC, S_MIN, S_MINW
// and S_RES before out_valid rises. A sift reads the slot and its parent to
// decide its direction, rereads the slot and its children when it turns
// downward, and moves each level by an exchange in S_SWP; the remove of an
// inner slot first moves the last slot into the hole. in_ready is high again
// in the cycle in which out_valid rises. Every slot read goes through the
// single read port of the slot memory, one read a cycle.
// After reset a clearing pass writes the absent marker into all 1024 entries
// of the position map; in_ready stays low until it ends.
// The result sits in an output register; the next transaction is accepted
// while it waits, and the block stalls only when a second result is ready
// before the first one has been taken.
module indexed_deadline_min_heap #(
  parameter int unsigned CAPACITY      = idmh_pkg::CAPACITY_DEF,
  parameter int unsigned DEADLINE_BITS = idmh_pkg::DEADLINE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_operation,
  input  logic [idmh_pkg::ID_BITS-1:0]         in_entry_id,
  input  logic [47:0]                          in_new_deadline,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic                                 out_min_valid,
  output logic [idmh_pkg::DL_OUT_BITS-1:0]     out_min_deadline,
  output logic [idmh_pkg::ID_BITS-1:0]         out_min_entry,
  output logic [idmh_pkg::CNT_OUT_BITS-1:0]    out_count
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = DEADLINE_BITS;
  localparam int unsigned IW = idmh_pkg::ID_BITS;
  localparam int unsigned SW = DW + IW;
  localparam logic [PW-1:0] ABSENT = PW'(CAPACITY);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_POS   = 12'b000000000100,
    S_DEC   = 12'b000000001000,
    S_RDK   = 12'b000000010000,
    S_RDA   = 12'b000000100000,
    S_RDB   = 12'b000001000000,
    S_CMP   = 12'b000010000000,
    S_SWP   = 12'b000100000000,
    S_MIN   = 12'b001000000000,
    S_MINW  = 12'b010000000000,
    S_RES   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic                op_r, op_nxt;
  logic [IW-1:0]       id_r, id_nxt;
  logic [DW-1:0]       dl_r, dl_nxt;
  logic [PW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       k_r, k_nxt;
  logic [AW-1:0]       a_r, a_nxt;
  logic [AW-1:0]       b_r, b_nxt;
  logic                a_ok_r, a_ok_nxt;
  logic                b_ok_r, b_ok_nxt;
  logic                up_r, up_nxt;      // sift direction: 1 up, 0 down
  logic                first_r, first_nxt; // first level decides direction
  logic [SW-1:0]       vk_r, vk_nxt;
  logic [SW-1:0]       va_r, va_nxt;
  logic [1:0]          st_r, st_nxt;
  logic [IW:0]         clr_r, clr_nxt;
  logic [AW-1:0]       swp_t_r, swp_t_nxt;
  logic                swp_ph_r, swp_ph_nxt;

  logic                ov_r, ov_nxt;
  idmh_pkg::res_ctl_t  octl_r, octl_nxt;
  logic [DW-1:0]       omd_r, omd_nxt;
  logic [IW-1:0]       ome_r, ome_nxt;
  logic [PW-1:0]       ocnt_r, ocnt_nxt;

  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata;
  logic          p_we;
  logic [IW-1:0] p_waddr, p_raddr;
  logic [PW-1:0] p_wdata, p_rdata;

  idmh_slot_mem #(.CAPACITY(CAPACITY), .DW(DW), .AW(AW)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  idmh_pos_mem #(.PW(PW)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  function automatic logic [DW-1:0] dl_of(input logic [SW-1:0] v);
    dl_of = v[SW-1:IW];
  endfunction

  function automatic logic [IW-1:0] id_of(input logic [SW-1:0] v);
    id_of = v[IW-1:0];
  endfunction

  logic        out_free;
  logic [PW:0] k_ext;
  logic [PW:0] l_ext;
  logic [PW:0] r_ext;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign k_ext = {{(PW+1-AW){1'b0}}, k_r};
  assign l_ext = (k_ext << 1) + 1'b1;
  assign r_ext = (k_ext << 1) + 2'd2;

  always_comb begin
    logic          present;
    logic [PW-1:0] pos;
    logic          b_win;
    logic [AW-1:0] best;
    logic          move;

    state_nxt = state_r;
    op_nxt = op_r; id_nxt = id_r; dl_nxt = dl_r; cnt_nxt = cnt_r;
    k_nxt = k_r; a_nxt = a_r; b_nxt = b_r;
    a_ok_nxt = a_ok_r; b_ok_nxt = b_ok_r; up_nxt = up_r; first_nxt = first_r;
    vk_nxt = vk_r; va_nxt = va_r; st_nxt = st_r;
    clr_nxt = clr_r; swp_t_nxt = swp_t_r; swp_ph_nxt = swp_ph_r;
    ov_nxt = ov_r && !out_ready;
    octl_nxt = octl_r; omd_nxt = omd_r; ome_nxt = ome_r; ocnt_nxt = ocnt_r;

    s_we = 1'b0; s_waddr = k_r; s_wdata = vk_r; s_raddr = k_r;
    // The position lookup uses the latched id, since the input may change
    // right after acceptance.
    p_we = 1'b0; p_waddr = id_r; p_wdata = ABSENT; p_raddr = id_r;

    present = 1'b0; pos = '0; b_win = 1'b0; best = k_r; move = 1'b0;

    case (state_r)
      S_CLEAR: begin
        p_we = 1'b1;
        p_waddr = clr_r[IW-1:0];
        p_wdata = ABSENT;
        clr_nxt = clr_r + 1'b1;
        if (clr_r[IW-1:0] == IW'(idmh_pkg::ENTRY_IDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_operation;
          id_nxt = in_entry_id;
          dl_nxt = DW'(in_new_deadline);
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        state_nxt = S_DEC;
      end
      S_DEC: begin
        pos = p_rdata;
        present = (pos < cnt_r);
        st_nxt = idmh_pkg::ST_DONE;
        k_nxt = pos[AW-1:0];
        first_nxt = 1'b1;
        state_nxt = S_RDK;
        if (op_r == idmh_pkg::OP_UPSERT) begin
          if (!present) begin
            if (cnt_r >= PW'(CAPACITY)) begin
              st_nxt = idmh_pkg::ST_FULL;
              state_nxt = S_MIN;
            end else begin
              k_nxt = cnt_r[AW-1:0];
              s_we = 1'b1;
              s_waddr = cnt_r[AW-1:0];
              s_wdata = {dl_r, id_r};
              p_we = 1'b1;
              p_waddr = id_r;
              p_wdata = cnt_r;
              cnt_nxt = cnt_r + 1'b1;
            end
          end else begin
            s_we = 1'b1;
            s_waddr = pos[AW-1:0];
            s_wdata = {dl_r, id_r};
          end
        end else begin
          p_we = 1'b1;
          p_waddr = id_r;
          p_wdata = ABSENT;
          if (!present) begin
            st_nxt = idmh_pkg::ST_ABSENT;
            state_nxt = S_MIN;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
            if (pos == cnt_r - 1'b1) begin
              state_nxt = S_MIN;
            end else begin
              // Move the last slot into the hole, then re-sift it.
              s_raddr = AW'(cnt_r - 1'b1);
              state_nxt = S_SWP;
              swp_ph_nxt = 1'b1;
            end
          end
        end
      end
      S_SWP: begin
        if (swp_ph_r) begin
          // Read data of the last slot arrives now.
          s_we = 1'b1;
          s_waddr = k_r;
          s_wdata = s_rdata;
          p_we = 1'b1;
          p_waddr = id_of(s_rdata);
          p_wdata = PW'(k_r);
          swp_ph_nxt = 1'b0;
          state_nxt = S_RDK;
        end else begin
          // Second half of an exchange: write k's item into the other slot and map its position.
          s_we = 1'b1;
          s_waddr = swp_t_r;
          s_wdata = vk_r;
          p_we = 1'b1;
          p_waddr = id_of(vk_r);
          p_wdata = PW'(swp_t_r);
          k_nxt = swp_t_r;
          state_nxt = S_RDK;
        end
      end
      S_RDK: begin
        s_raddr = k_r;
        state_nxt = S_RDA;
      end
      S_RDA: begin
        vk_nxt = s_rdata;
        if (first_r) begin
          a_nxt = AW'((k_ext - 1'b1) >> 1);
          a_ok_nxt = (k_r != '0);
          b_ok_nxt = 1'b0;
          s_raddr = AW'((k_ext - 1'b1) >> 1);
        end else if (up_r) begin
          a_nxt = AW'((k_ext - 1'b1) >> 1);
          a_ok_nxt = (k_r != '0);
          b_ok_nxt = 1'b0;
          s_raddr = AW'((k_ext - 1'b1) >> 1);
        end else begin
          a_nxt = AW'(l_ext);
          a_ok_nxt = (l_ext < {1'b0, cnt_r});
          s_raddr = AW'(l_ext);
        end
        b_nxt = AW'(r_ext);
        state_nxt = S_RDB;
      end
      S_RDB: begin
        va_nxt = s_rdata;
        s_raddr = b_r;
        if (first_r || up_r) begin
          b_ok_nxt = 1'b0;
        end else begin
          b_ok_nxt = (r_ext < {1'b0, cnt_r});
        end
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (first_r) begin
          up_nxt = a_ok_r && (dl_of(va_r) > dl_of(vk_r));
          first_nxt = 1'b0;
          if (!(a_ok_r && (dl_of(va_r) > dl_of(vk_r)))) begin
            // Go down: reread children.
            state_nxt = S_RDK;
          end else begin
            state_nxt = S_SWP;
          end
          if (a_ok_r && (dl_of(va_r) > dl_of(vk_r))) begin
            move = 1'b1;
            best = a_r;
          end
        end else if (up_r) begin
          move = a_ok_r && (dl_of(va_r) > dl_of(vk_r));
          best = a_r;
          state_nxt = move ? S_SWP : S_MIN;
        end else begin
          b_win = b_ok_r && (dl_of(s_rdata) < dl_of(va_r));
          if (a_ok_r && (dl_of(va_r) < dl_of(vk_r)) && !b_win) begin
            move = 1'b1;
            best = a_r;
          end else if (b_ok_r && (dl_of(s_rdata) < dl_of(vk_r)) &&
                       (!a_ok_r || dl_of(s_rdata) < dl_of(va_r))) begin
            move = 1'b1;
            best = b_r;
          end
          state_nxt = move ? S_SWP : S_MIN;
        end
        if (move) begin
          // Write the other slot's item into k now, k's item into best next.
          s_we = 1'b1;
          s_waddr = k_r;
          s_wdata = (best == a_r) ? va_r : s_rdata;
          p_we = 1'b1;
          p_waddr = (best == a_r) ? id_of(va_r) : id_of(s_rdata);
          p_wdata = PW'(k_r);
          swp_t_nxt = best;
          swp_ph_nxt = 1'b0;
        end
      end
      S_MIN: begin
        s_raddr = '0;
        state_nxt = S_MINW;
      end
      S_MINW: begin
        state_nxt = S_RES;
        va_nxt = s_rdata;
      end
      S_RES: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          octl_nxt.status = st_r;
          octl_nxt.min_valid = (cnt_r != '0);
          omd_nxt = (cnt_r != '0) ? dl_of(va_r) : '0;
          ome_nxt = (cnt_r != '0) ? id_of(va_r) : '0;
          ocnt_nxt = cnt_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r <= '0;
      clr_r <= '0;
      ov_r <= 1'b0;
      first_r <= 1'b0;
      up_r <= 1'b0;
      swp_ph_r <= 1'b0;
      st_r <= idmh_pkg::ST_DONE;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
      first_r <= first_nxt;
      up_r <= up_nxt;
      swp_ph_r <= swp_ph_nxt;
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; id_r <= id_nxt; dl_r <= dl_nxt;
    k_r <= k_nxt; a_r <= a_nxt; b_r <= b_nxt;
    a_ok_r <= a_ok_nxt; b_ok_r <= b_ok_nxt;
    vk_r <= vk_nxt; va_r <= va_nxt;
    swp_t_r <= swp_t_nxt;
    octl_r <= octl_nxt; omd_r <= omd_nxt; ome_r <= ome_nxt; ocnt_r <= ocnt_nxt;
  end

  assign out_valid = ov_r;
  assign out_status = octl_r.status;
  assign out_min_valid = octl_r.min_valid;
  assign out_min_deadline = idmh_pkg::DL_OUT_BITS'(omd_r);
  assign out_min_entry = ome_r;
  assign out_count = idmh_pkg::CNT_OUT_BITS'(ocnt_r);
endmodule

// ===== rtl/idmh_pos_mem.sv =====
// Position map from entry id to heap slot, synchronous RAM with registered read.
// Uses idmh_pkg. The top level clears every entry to the absent marker.
module idmh_pos_mem #(
  parameter int unsigned PW = 11
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [idmh_pkg::ID_BITS-1:0]   waddr,
  input  logic [PW-1:0]                  wdata,
  input  logic [idmh_pkg::ID_BITS-1:0]   raddr,
  output logic [PW-1:0]                  rdata
);
  logic [PW-1:0] mem [idmh_pkg::ENTRY_IDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/idmh_slot_mem.sv =====
// Heap slot memory holding (deadline, entry id) per slot; one write, one read port.
// Uses idmh_pkg. Contents are undefined until written.
module idmh_slot_mem #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned DW       = 48,
  parameter int unsigned AW       = 10
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [AW-1:0]                       waddr,
  input  logic [DW+idmh_pkg::ID_BITS-1:0]     wdata,
  input  logic [AW-1:0]                       raddr,
  output logic [DW+idmh_pkg::ID_BITS-1:0]     rdata
);
  logic [DW+idmh_pkg::ID_BITS-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/idmh_checker.sv =====
// Port-level checker for the indexed deadline min-heap, bound to the top level.
// Uses idmh_pkg and indexed_deadline_min_heap_macros.svh.
`include "indexed_deadline_min_heap_macros.svh"
module idmh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_min_valid,
  input logic [47:0] out_min_deadline,
  input logic [9:0]  out_min_entry,
  input logic [10:0] out_count
);
  `IDMH_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_count))
  `IDMH_ASSERT_IMP(a_min_matches_count, clk, rst_n, out_valid, out_min_valid == (out_count != 11'd0))
  `IDMH_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid && !out_min_valid, out_min_deadline == 48'd0 && out_min_entry == 10'd0)
  `IDMH_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_status == idmh_pkg::ST_DONE || out_status == idmh_pkg::ST_FULL || out_status == idmh_pkg::ST_ABSENT)
  `IDMH_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind indexed_deadline_min_heap idmh_checker u_idmh_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_min_valid(out_min_valid), .out_min_deadline(out_min_deadline),
  .out_min_entry(out_min_entry), .out_count(out_count)
);

// ===== sim/tb.sv =====
// Self-checking testbench of the indexed deadline min-heap.
// Depends on idmh_pkg and indexed_deadline_min_heap; predicts each result
// with its own heap model and compares every result transaction field by field.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = 1024;
  localparam int unsigned NO_SLOT = CAP;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam longint unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic        operation;
    logic [9:0]  entry_id;
    logic [47:0] new_deadline;
  } heap_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        min_valid;
    logic [47:0] min_deadline;
    logic [9:0]  min_entry;
    logic [10:0] count;
  } heap_view_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_operation;
  logic [9:0] in_entry_id;
  logic [47:0] in_new_deadline;
  logic out_valid, out_ready, out_min_valid;
  logic [1:0] out_status;
  logic [47:0] out_min_deadline;
  logic [9:0] out_min_entry;
  logic [10:0] out_count;

  indexed_deadline_min_heap i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_entry_id(in_entry_id), .in_new_deadline(in_new_deadline),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_min_valid(out_min_valid), .out_min_deadline(out_min_deadline),
    .out_min_entry(out_min_entry), .out_count(out_count)
  );

  // Predictor state.
  logic [47:0] pred_deadline [CAP];
  logic [9:0]  pred_entry [CAP];
  int unsigned pred_pos [1024] = '{default: NO_SLOT};
  int unsigned pred_count = 0;

  heap_op_t   pending_ops[$];
  heap_view_t accepted_views[$];
  int unsigned error_count = 0;
  bit quiet_phase;
  longint unsigned cycle_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  task automatic enqueue_op(input heap_op_t t);
    pending_ops = {pending_ops, t};
  endtask

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [47:0] d;
    logic [9:0] e;
    d = pred_deadline[a];
    e = pred_entry[a];
    pred_deadline[a] = pred_deadline[b];
    pred_entry[a] = pred_entry[b];
    pred_deadline[b] = d;
    pred_entry[b] = e;
    pred_pos[pred_entry[a]] = a;
    pred_pos[pred_entry[b]] = b;
  endfunction

  function automatic void float_up(int unsigned k);
    while (k > 0 && pred_deadline[(k - 1) / 2] > pred_deadline[k]) begin
      swap_slots(k, (k - 1) / 2);
      k = (k - 1) / 2;
    end
  endfunction

  function automatic void sink_down(int unsigned k);
    int unsigned best;
    forever begin
      best = k;
      if (2 * k + 1 < pred_count && pred_deadline[2 * k + 1] < pred_deadline[best])
        best = 2 * k + 1;
      if (2 * k + 2 < pred_count && pred_deadline[2 * k + 2] < pred_deadline[best])
        best = 2 * k + 2;
      if (best == k) break;
      swap_slots(k, best);
      k = best;
    end
  endfunction

  function automatic void reposition(int unsigned k);
    if (k > 0 && pred_deadline[(k - 1) / 2] > pred_deadline[k]) float_up(k);
    else sink_down(k);
  endfunction

  function automatic heap_view_t apply_heap_op(heap_op_t op);
    heap_view_t v;
    int unsigned pos, last;
    bit present;
    pos = pred_pos[op.entry_id];
    present = pos < pred_count;
    v = '0;
    v.status = idmh_pkg::ST_DONE;
    if (op.operation == idmh_pkg::OP_UPSERT) begin
      if (!present) begin
        if (pred_count >= CAP) begin
          v.status = idmh_pkg::ST_FULL;
        end else begin
          pos = pred_count;
          pred_deadline[pos] = op.new_deadline;
          pred_entry[pos] = op.entry_id;
          pred_pos[op.entry_id] = pos;
          pred_count++;
          float_up(pos);
        end
      end else begin
        pred_deadline[pos] = op.new_deadline;
        reposition(pos);
      end
    end else begin
      if (!present) begin
        v.status = idmh_pkg::ST_ABSENT;
        pred_pos[op.entry_id] = NO_SLOT;
      end else begin
        last = pred_count - 1;
        if (pos != last) swap_slots(pos, last);
        pred_count--;
        pred_pos[op.entry_id] = NO_SLOT;
        if (pos < pred_count) reposition(pos);
      end
    end
    if (pred_count > 0) begin
      v.min_valid = 1'b1;
      v.min_deadline = pred_deadline[0];
      v.min_entry = pred_entry[0];
    end
    v.count = pred_count[10:0];
    return v;
  endfunction

  function automatic logic [47:0] rand_deadline();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 48'($urandom_range(0, 15));
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic heap_op_t make_op(logic op, logic [9:0] id, logic [47:0] dl);
    heap_op_t t;
    t.operation = op;
    t.entry_id = id;
    t.new_deadline = dl;
    return t;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: presents the queued operations; valid holds until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_operation <= 1'b0;
      in_entry_id <= '0;
      in_new_deadline <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_ops.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 12)) begin
        in_valid <= 1'b1;
        {in_operation, in_entry_id, in_new_deadline} <= pending_ops.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  heap_view_t got;
  heap_view_t want;
  // Monitor: predicts on accepted operations and checks accepted results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_status, out_min_valid, out_min_deadline, out_min_entry, out_count};
        if (accepted_views.size() == 0) begin
          report_mismatch("unexpected result", 64'(got.count), 64'd0);
        end else begin
          want = accepted_views.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.min_valid !== want.min_valid)
            report_mismatch("min_valid", 64'(got.min_valid), 64'(want.min_valid));
          if (got.min_deadline !== want.min_deadline)
            report_mismatch("min_deadline", 64'(got.min_deadline), 64'(want.min_deadline));
          if (got.min_entry !== want.min_entry)
            report_mismatch("min_entry", 64'(got.min_entry), 64'(want.min_entry));
          if (got.count !== want.count)
            report_mismatch("count", 64'(got.count), 64'(want.count));
        end
      end
      if (in_valid && in_ready)
        accepted_views = {accepted_views,
                          apply_heap_op(heap_op_t'({in_operation, in_entry_id,
                                                    in_new_deadline}))};
      out_ready <= quiet_phase || ($urandom_range(0, 99) >= 12);
    end else begin
      out_ready <= 1'b0;
    end
  end

  initial begin
    int unsigned id_bias;
    rst_n = 1'b0;
    quiet_phase = 1'b0;
    // Directed part: absent removes, extreme keys, ties, re-keys up and down.
    enqueue_op(make_op(idmh_pkg::OP_REMOVE, 10'd5, '1));
    enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'd1023, '1));
    enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'd0, '0));
    enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'd7, '0));
    enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'd8, 48'd100));
    enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'd9, 48'd100));
    enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'd1023, 48'd1));
    enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'd0, 48'hAAAA_5555_AAAA));
    enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'h155, 48'h5555_AAAA_5555));
    enqueue_op(make_op(idmh_pkg::OP_REMOVE, 10'd7, '0));
    enqueue_op(make_op(idmh_pkg::OP_REMOVE, 10'd7, '0));
    enqueue_op(make_op(idmh_pkg::OP_REMOVE, 10'd1023, '0));
    enqueue_op(make_op(idmh_pkg::OP_REMOVE, 10'd9, '0));
    enqueue_op(make_op(idmh_pkg::OP_REMOVE, 10'd8, '0));
    enqueue_op(make_op(idmh_pkg::OP_REMOVE, 10'h155, '0));
    enqueue_op(make_op(idmh_pkg::OP_REMOVE, 10'd0, '0));
    enqueue_op(make_op(idmh_pkg::OP_REMOVE, 10'h2AA, '0));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // Random part: mostly upserts, with re-keys and removes; ids come from a small
    // pool for the first 400 items and from all ids after that.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      id_bias = (n < 400) ? 63 : 1023;
      if ($urandom_range(0, 99) < 60)
        enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'($urandom_range(0, id_bias)),
                           rand_deadline()));
      else
        enqueue_op(make_op(idmh_pkg::OP_REMOVE, 10'($urandom_range(0, id_bias)),
                           rand_deadline()));
    end
    // Fill the heap to capacity, re-key a member while full, then drain part
    // of it; only the start of the fill runs without idling.
    for (int n = 0; n < 1024; n++)
      enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'(n), rand_deadline()));
    enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'd3, '0));
    for (int n = 0; n < 200; n++)
      enqueue_op(make_op(idmh_pkg::OP_REMOVE, 10'(n ^ 10'h2A5), '0));
    enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'd0, '0));
    enqueue_op(make_op(idmh_pkg::OP_REMOVE, 10'd1023, '0));
    enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'd1023, '0));
    enqueue_op(make_op(idmh_pkg::OP_UPSERT, 10'd512, '0));
    while (pending_ops.size() > 0 || in_valid) begin
      quiet_phase = (pending_ops.size() > 1000 && pending_ops.size() < 1400);
      @(posedge clk);
    end
    quiet_phase = 1'b0;
    while (accepted_views.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end
endmodule
